@@ rtl/afd_pkg.sv @@
// shared types and constants for the fall direction detector
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int ORIENT_W    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SAMPLE_W-1:0] MIDPOINT_RESET = 10'd512;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_UPRIGHT  = 3'd0,
        ORIENT_LEFT     = 3'd1,
        ORIENT_RIGHT    = 3'd2,
        ORIENT_FORWARD  = 3'd3,
        ORIENT_BACKWARD = 3'd4
    } orient_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

endpackage

`default_nettype wire

@@ rtl/accel_fall_direction_detector.sv @@
// top level of the accelerometer fall direction detector
//
// input channel: one three-axis sample beat (acc_x, acc_y, acc_z) is taken at a
// rising edge with push high and full low; full low sustains one beat per cycle
// output channel: orientation is valid while empty is low and is taken at a
// rising edge with pop high; a stalled result holds until popped
// the first WINDOW - 1 samples after reset only fill the window and give no
// result; every later sample gives exactly one orientation beat
// a sample passes the window read, the running-sum update into the queue,
// centring, then compare into the result register, where empty goes low
// throughput: one sample per cycle while full stays low
// the four-entry queue between sum front end and compare back end absorbs a
// stalled receiver; full rises once queue plus in-flight results reach four
// cfg_wr_en writes midpoint_reg at once; write only while idle
// reset: sums, fill count and write slot clear, midpoint returns to 512,
// queue and output stages empty
`timescale 1ns / 1ps
`default_nettype none

module accel_fall_direction_detector #(
    parameter int WINDOW = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]  cfg_wr_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]  acc_x,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]  acc_y,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]  acc_z,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [afd_pkg::ORIENT_W-1:0]       orientation
);

    localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
    localparam int QD    = afd_pkg::QUEUE_DEPTH;

    logic [afd_pkg::SAMPLE_W-1:0] midpoint_reg;
    afd_pkg::q_status_t           q_stat;
    logic                         q_push, q_pop;
    logic [3*SUM_W-1:0]           q_wr_data, q_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            midpoint_reg <= afd_pkg::MIDPOINT_RESET;
        else if (cfg_wr_en)
            midpoint_reg <= cfg_wr_data;
    end

    afd_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .acc_x  (acc_x),
        .acc_y  (acc_y),
        .acc_z  (acc_z),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    afd_queue #(
        .DATA_W (3 * SUM_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .q_stat  (q_stat)
    );

    afd_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .midpoint    (midpoint_reg),
        .q_stat      (q_stat),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .orientation (orientation)
    );

`ifndef SYNTH
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.count < QD))
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_full_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.count == QD) |-> full)
        else $error("input open with queue full");
`endif

endmodule

`default_nettype wire

@@ rtl/afd_front.sv @@
// front end: sample windows, fill tracking and running sums per axis
`timescale 1ns / 1ps
`default_nettype none

module afd_front #(
    parameter int WINDOW = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]   acc_x,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]   acc_y,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]   acc_z,
    input  wire afd_pkg::q_status_t             q_stat,
    output logic                                q_push,
    output logic [3*$clog2(WINDOW*1023+1)-1:0]  q_data
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
    localparam int SW    = afd_pkg::SAMPLE_W;

    logic [SW-1:0] x_win_mem [WINDOW];
    logic [SW-1:0] y_win_mem [WINDOW];
    logic [SW-1:0] z_win_mem [WINDOW];

    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic          a_valid_reg, a_valid_next;
    logic          a_res_reg;
    logic          a_evict_reg;
    logic [SW-1:0] a_x_reg, a_y_reg, a_z_reg;
    logic [SW-1:0] ev_x_reg, ev_y_reg, ev_z_reg;

    logic [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;

    logic [afd_pkg::QCNT_W:0] reserved;
    logic                     accept;

    // queue slots already taken plus a result still in flight
    always_comb
    begin
        reserved = {1'b0, q_stat.count} + {{afd_pkg::QCNT_W{1'b0}}, a_valid_reg & a_res_reg};
        full     = (reserved >= (afd_pkg::QCNT_W+1)'(afd_pkg::QUEUE_DEPTH));
        accept   = push & ~full;
    end

    always_comb
    begin
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        a_valid_next = accept;
        if (accept)
        begin
            if (slot_reg == IDX_W'(WINDOW - 1))
                slot_next = '0;
            else
                slot_next = slot_reg + IDX_W'(1);
            if (fill_reg != CNT_W'(WINDOW))
                fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            fill_reg    <= '0;
            a_valid_reg <= 1'b0;
            a_res_reg   <= 1'b0;
            a_evict_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            a_valid_reg <= a_valid_next;
            if (accept)
            begin
                a_res_reg   <= (fill_reg >= CNT_W'(WINDOW - 1));
                a_evict_reg <= (fill_reg == CNT_W'(WINDOW));
            end
        end
    end

    // read of the evicted entry happens before the overwrite
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_x_reg            <= x_win_mem[slot_reg];
            ev_y_reg            <= y_win_mem[slot_reg];
            ev_z_reg            <= z_win_mem[slot_reg];
            x_win_mem[slot_reg] <= acc_x;
            y_win_mem[slot_reg] <= acc_y;
            z_win_mem[slot_reg] <= acc_z;
            a_x_reg             <= acc_x;
            a_y_reg             <= acc_y;
            a_z_reg             <= acc_z;
        end
    end

    // slots never written count as zero
    always_comb
    begin
        sum_x_next = sum_x_reg + SUM_W'(a_x_reg);
        sum_y_next = sum_y_reg + SUM_W'(a_y_reg);
        sum_z_next = sum_z_reg + SUM_W'(a_z_reg);
        if (a_evict_reg)
        begin
            sum_x_next = sum_x_reg + SUM_W'(a_x_reg) - SUM_W'(ev_x_reg);
            sum_y_next = sum_y_reg + SUM_W'(a_y_reg) - SUM_W'(ev_y_reg);
            sum_z_next = sum_z_reg + SUM_W'(a_z_reg) - SUM_W'(ev_z_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end
        else if (a_valid_reg)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            sum_z_reg <= sum_z_next;
        end
    end

    assign q_push = a_valid_reg & a_res_reg;
    assign q_data = {sum_z_next, sum_y_next, sum_x_next};

endmodule

`default_nettype wire

@@ rtl/afd_queue.sv @@
// short show-ahead queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module afd_queue #(
    parameter int DATA_W = 45
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      rd_data,
    output afd_pkg::q_status_t     q_stat
);

    localparam int PW = afd_pkg::QPTR_W;
    localparam int CW = afd_pkg::QCNT_W;

    logic [DATA_W-1:0] q_mem [afd_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    always_comb
    begin
        do_pop      = pop & (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(afd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(afd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (!push && do_pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data      = q_mem[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/afd_back.sv @@
// back end: centring, magnitude compare and result register
`timescale 1ns / 1ps
`default_nettype none

module afd_back #(
    parameter int WINDOW = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]   midpoint,
    input  wire afd_pkg::q_status_t             q_stat,
    input  wire logic [3*$clog2(WINDOW*1023+1)-1:0] q_data,
    output logic                                q_pop,
    input  wire logic                           pop,
    output logic                                empty,
    output logic [afd_pkg::ORIENT_W-1:0]        orientation
);

    localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
    localparam int CEN_W = SUM_W + 1;

    logic [SUM_W-1:0] mid_scaled;
    logic [SUM_W-1:0] sx, sy, sz;

    logic                    c_valid_reg, c_valid_next;
    logic signed [CEN_W-1:0] cx_reg, cy_reg, cz_reg;

    logic             d_valid_reg, d_valid_next;
    afd_pkg::orient_t orient_reg, orient_next;

    logic [CEN_W-1:0] mx, my, mz;
    logic             d_ready, c_ready;

    assign d_ready = ~d_valid_reg | pop;
    assign c_ready = ~c_valid_reg | d_ready;
    assign q_pop   = ~q_stat.empty & c_ready;

    assign {sz, sy, sx} = q_data;
    assign mid_scaled   = SUM_W'(WINDOW) * SUM_W'(midpoint);

    always_comb
    begin
        c_valid_next = c_valid_reg;
        if (c_ready)
            c_valid_next = q_pop;
        d_valid_next = d_valid_reg;
        if (d_ready)
            d_valid_next = c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cx_reg <= $signed({1'b0, sx}) - $signed({1'b0, mid_scaled});
            cy_reg <= $signed({1'b0, sy}) - $signed({1'b0, mid_scaled});
            cz_reg <= $signed({1'b0, sz}) - $signed({1'b0, mid_scaled});
        end
        if (d_ready && c_valid_reg)
            orient_reg <= orient_next;
    end

    // a tie of x and y falls to the y branch; z wins only when strictly largest
    always_comb
    begin
        mx = cx_reg[CEN_W-1] ? CEN_W'(-cx_reg) : CEN_W'(cx_reg);
        my = cy_reg[CEN_W-1] ? CEN_W'(-cy_reg) : CEN_W'(cy_reg);
        mz = cz_reg[CEN_W-1] ? CEN_W'(-cz_reg) : CEN_W'(cz_reg);
        if (mz > mx && mz > my)
            orient_next = afd_pkg::ORIENT_UPRIGHT;
        else if (mx > my)
            orient_next = cx_reg[CEN_W-1] ? afd_pkg::ORIENT_RIGHT : afd_pkg::ORIENT_LEFT;
        else
            orient_next = cy_reg[CEN_W-1] ? afd_pkg::ORIENT_FORWARD : afd_pkg::ORIENT_BACKWARD;
    end

    assign empty       = ~d_valid_reg;
    assign orientation = orient_reg;

endmodule

`default_nettype wire
